// ----- hw/rtl/apdll_pkg.sv -----
// Package for the array-pool doubly linked list: sizes, codes, state type and the
// command/flag structs passed between controller and datapath. No dependencies.
`default_nettype none

package apdll_pkg;

	localparam int POOL_SLOTS = 16;
	localparam int TEXT_BITS  = 64;
	localparam int IDX_W      = $clog2(POOL_SLOTS);
	localparam int LINK_W     = $clog2(POOL_SLOTS + 1);
	localparam int OP_W       = 3;
	localparam int ST_W       = 2;
	localparam int NUM_W      = 32;
	localparam int WORD_W     = 64;

	// Link value meaning "no slot"
	localparam logic [LINK_W-1:0] NONE_LINK = LINK_W'(POOL_SLOTS);

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR     = 3'd0,
		OP_ADD_FIRST = 3'd1,
		OP_ADD_AFTER = 3'd2,
		OP_ADD_LAST  = 3'd3,
		OP_DEL_FIRST = 3'd4,
		OP_DEL_AFTER = 3'd5,
		OP_DEL_LAST  = 3'd6,
		OP_READ      = 3'd7
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPOS = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_FETCH,
		S_LINK,
		S_COMMIT,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic accept;
		logic check;
		logic fetch;
		logic link;
		logic commit;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic is_insert;
		logic is_delete;
		logic check_ok;
		logic fetch_ok;
	} flags_t;

endpackage

`default_nettype wire

// ----- hw/rtl/array_pool_doubly_linked_list_top.sv -----
// Sequence: a start accepted in idle or finish enters check; clear, read and flagged operations
// go on to finish, an add runs link and commit, and a delete runs fetch, link and commit, but a
// delete-after whose position is the tail goes from fetch to finish. The new entry's links are
// written during link and neighbor links during commit, through one write port per link memory.
// Overlap: the next word is taken during the finish step; done is registered from that step.
// Reset: arst_n clears head, tail, count and in-use bits; slot memories hold no reset.
`default_nettype none

module array_pool_doubly_linked_list_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic [apdll_pkg::OP_W-1:0]         operation,
	input  wire logic [apdll_pkg::IDX_W-1:0]        position,
	input  wire logic signed [apdll_pkg::NUM_W-1:0] number_value,
	input  wire logic [apdll_pkg::WORD_W-1:0]       text_word,
	output logic                                    done,
	output logic [apdll_pkg::ST_W-1:0]              status,
	output logic [apdll_pkg::IDX_W-1:0]             slot,
	output logic [apdll_pkg::LINK_W-1:0]            count,
	output logic [apdll_pkg::LINK_W-1:0]            head_link,
	output logic [apdll_pkg::LINK_W-1:0]            tail_link,
	output logic [apdll_pkg::LINK_W-1:0]            prev_link,
	output logic [apdll_pkg::LINK_W-1:0]            next_link,
	output logic signed [apdll_pkg::NUM_W-1:0]      read_number,
	output logic [apdll_pkg::WORD_W-1:0]            read_text
);

	apdll_pkg::cmd_t   cmd;
	apdll_pkg::flags_t flags;

	apdll_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.flags  (flags),
		.cmd    (cmd),
		.busy   (busy)
	);

	apdll_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.operation    (operation),
		.position     (position),
		.number_value (number_value),
		.text_word    (text_word),
		.flags        (flags),
		.done         (done),
		.status       (status),
		.slot         (slot),
		.count        (count),
		.head_link    (head_link),
		.tail_link    (tail_link),
		.prev_link    (prev_link),
		.next_link    (next_link),
		.read_number  (read_number),
		.read_text    (read_text)
	);

endmodule

`default_nettype wire

// ----- hw/rtl/apdll_ctrl.sv -----
// Controller state machine of the linked-list pool: sequences check, fetch, link,
// commit and finish steps. Depends on apdll_pkg.
`default_nettype none

module apdll_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  apdll_pkg::flags_t    flags,
	output apdll_pkg::cmd_t      cmd,
	output logic                 busy
);

	apdll_pkg::state_t state_q;
	apdll_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= apdll_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			apdll_pkg::S_IDLE: begin
				if (start) state_d = apdll_pkg::S_CHECK;
			end
			apdll_pkg::S_CHECK: begin
				if (!flags.check_ok)     state_d = apdll_pkg::S_FINISH;
				else if (flags.is_insert) state_d = apdll_pkg::S_LINK;
				else if (flags.is_delete) state_d = apdll_pkg::S_FETCH;
				else                     state_d = apdll_pkg::S_FINISH;
			end
			apdll_pkg::S_FETCH: begin
				state_d = flags.fetch_ok ? apdll_pkg::S_LINK : apdll_pkg::S_FINISH;
			end
			apdll_pkg::S_LINK: begin
				state_d = apdll_pkg::S_COMMIT;
			end
			apdll_pkg::S_COMMIT: begin
				state_d = apdll_pkg::S_FINISH;
			end
			apdll_pkg::S_FINISH: begin
				// a new word may enter while the result is being registered
				state_d = start ? apdll_pkg::S_CHECK : apdll_pkg::S_IDLE;
			end
			default: begin
				state_d = apdll_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		busy       = 1'b1;
		cmd        = '0;
		case (state_q)
			apdll_pkg::S_IDLE:   busy = 1'b0;
			apdll_pkg::S_CHECK:  cmd.check = 1'b1;
			apdll_pkg::S_FETCH:  cmd.fetch = 1'b1;
			apdll_pkg::S_LINK:   cmd.link = 1'b1;
			apdll_pkg::S_COMMIT: cmd.commit = 1'b1;
			apdll_pkg::S_FINISH: begin
				busy       = 1'b0;
				cmd.finish = 1'b1;
			end
			default: busy = 1'b0;
		endcase
		cmd.accept = start && !busy;
	end

endmodule

`default_nettype wire

// ----- hw/rtl/apdll_dpath.sv -----
// Datapath of the linked-list pool: head/tail/count/in-use registers, link and
// payload memories, status checks and result registers. Depends on apdll_pkg.
`default_nettype none

module apdll_dpath (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  apdll_pkg::cmd_t                         cmd,
	input  wire logic [apdll_pkg::OP_W-1:0]         operation,
	input  wire logic [apdll_pkg::IDX_W-1:0]        position,
	input  wire logic signed [apdll_pkg::NUM_W-1:0] number_value,
	input  wire logic [apdll_pkg::WORD_W-1:0]       text_word,
	output apdll_pkg::flags_t                       flags,
	output logic                                    done,
	output logic [apdll_pkg::ST_W-1:0]              status,
	output logic [apdll_pkg::IDX_W-1:0]             slot,
	output logic [apdll_pkg::LINK_W-1:0]            count,
	output logic [apdll_pkg::LINK_W-1:0]            head_link,
	output logic [apdll_pkg::LINK_W-1:0]            tail_link,
	output logic [apdll_pkg::LINK_W-1:0]            prev_link,
	output logic [apdll_pkg::LINK_W-1:0]            next_link,
	output logic signed [apdll_pkg::NUM_W-1:0]      read_number,
	output logic [apdll_pkg::WORD_W-1:0]            read_text
);

	localparam int N  = apdll_pkg::POOL_SLOTS;
	localparam int IW = apdll_pkg::IDX_W;
	localparam int LW = apdll_pkg::LINK_W;
	localparam int TW = apdll_pkg::TEXT_BITS;
	localparam int NW = apdll_pkg::NUM_W;

	// captured word
	apdll_pkg::op_t          op_q;
	logic [IW-1:0]           pos_q;
	logic signed [NW-1:0]    num_q;
	logic [TW-1:0]           txt_q;

	// list state
	logic [LW-1:0]           head_q;
	logic [LW-1:0]           tail_q;
	logic [LW-1:0]           count_q;
	logic [N-1:0]            in_use_q;
	logic [IW-1:0]           free_q;

	// per-operation working registers
	apdll_pkg::status_t      status_q;
	logic [IW-1:0]           s_q;
	logic [LW-1:0]           p_q;
	logic [LW-1:0]           nx_q;

	// memories and their registered read data
	logic [LW-1:0]           prev_mem [N];
	logic [LW-1:0]           next_mem [N];
	logic signed [NW-1:0]    num_mem  [N];
	logic [TW-1:0]           txt_mem  [N];
	logic [LW-1:0]           prev_rd_q;
	logic [LW-1:0]           next_rd_q;
	logic signed [NW-1:0]    num_rd_q;
	logic [TW-1:0]           txt_rd_q;

	// result registers
	logic                    done_q;
	apdll_pkg::status_t      out_status_q;
	logic [IW-1:0]           out_slot_q;
	logic [LW-1:0]           out_count_q;
	logic [LW-1:0]           out_head_q;
	logic [LW-1:0]           out_tail_q;
	logic [LW-1:0]           out_prev_q;
	logic [LW-1:0]           out_next_q;
	logic signed [NW-1:0]    out_num_q;
	logic [TW-1:0]           out_txt_q;

	logic                    full;
	logic                    empty;
	logic                    pos_used;
	logic                    is_insert;
	logic                    is_delete;
	apdll_pkg::status_t      check_status;
	logic [LW-1:0]           ins_prev;
	logic [LW-1:0]           ins_next;
	logic [LW-1:0]           del_slot;
	logic                    fetch_bad;
	logic [IW-1:0]           rd_addr;
	logic [IW-1:0]           free_d;
	logic [LW-1:0]           s_link;

	logic                    next_we;
	logic [IW-1:0]           next_waddr;
	logic [LW-1:0]           next_wdata;
	logic                    prev_we;
	logic [IW-1:0]           prev_waddr;
	logic [LW-1:0]           prev_wdata;
	logic                    data_we;

	assign full      = count_q >= LW'(N);
	assign empty     = count_q == '0;
	assign pos_used  = in_use_q[pos_q];
	assign is_insert = op_q inside {apdll_pkg::OP_ADD_FIRST, apdll_pkg::OP_ADD_AFTER,
		apdll_pkg::OP_ADD_LAST};
	assign is_delete = op_q inside {apdll_pkg::OP_DEL_FIRST, apdll_pkg::OP_DEL_AFTER,
		apdll_pkg::OP_DEL_LAST};
	assign s_link    = LW'(s_q);

	always_comb begin
		case (op_q)
			apdll_pkg::OP_CLEAR: check_status = apdll_pkg::ST_OK;
			apdll_pkg::OP_ADD_FIRST,
			apdll_pkg::OP_ADD_LAST: begin
				check_status = full ? apdll_pkg::ST_FULL : apdll_pkg::ST_OK;
			end
			apdll_pkg::OP_ADD_AFTER: begin
				if (full)          check_status = apdll_pkg::ST_FULL;
				else if (!pos_used) check_status = apdll_pkg::ST_BADPOS;
				else               check_status = apdll_pkg::ST_OK;
			end
			apdll_pkg::OP_DEL_FIRST,
			apdll_pkg::OP_DEL_LAST: begin
				check_status = empty ? apdll_pkg::ST_EMPTY : apdll_pkg::ST_OK;
			end
			apdll_pkg::OP_DEL_AFTER: begin
				if (empty)         check_status = apdll_pkg::ST_EMPTY;
				else if (!pos_used) check_status = apdll_pkg::ST_BADPOS;
				else               check_status = apdll_pkg::ST_OK;
			end
			apdll_pkg::OP_READ: begin
				check_status = pos_used ? apdll_pkg::ST_OK : apdll_pkg::ST_BADPOS;
			end
			default: check_status = apdll_pkg::ST_OK;
		endcase
	end

	// predecessor of a new entry; none inserts at the front
	always_comb begin
		case (op_q)
			apdll_pkg::OP_ADD_AFTER: ins_prev = LW'(pos_q);
			apdll_pkg::OP_ADD_LAST:  ins_prev = tail_q;
			default:                 ins_prev = apdll_pkg::NONE_LINK;
		endcase
	end

	// slot to remove; for delete-after it comes from the link read at check
	always_comb begin
		case (op_q)
			apdll_pkg::OP_DEL_AFTER: del_slot = next_rd_q;
			apdll_pkg::OP_DEL_FIRST: del_slot = head_q;
			default:                 del_slot = tail_q;
		endcase
	end

	assign fetch_bad = (op_q == apdll_pkg::OP_DEL_AFTER) && (next_rd_q == apdll_pkg::NONE_LINK);
	assign ins_next  = (p_q == apdll_pkg::NONE_LINK) ? head_q : next_rd_q;

	always_comb begin
		if (cmd.fetch)                          rd_addr = del_slot[IW-1:0];
		else if (op_q == apdll_pkg::OP_ADD_LAST) rd_addr = tail_q[IW-1:0];
		else                                    rd_addr = pos_q;
	end

	// lowest free slot
	always_comb begin
		free_d = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (!in_use_q[i]) free_d = IW'(i);
		end
	end

	// memory write ports: new entry during link, neighbor links during commit
	always_comb begin
		data_we    = cmd.link && is_insert;
		next_we    = 1'b0;
		next_waddr = s_q;
		next_wdata = ins_next;
		prev_we    = 1'b0;
		prev_waddr = s_q;
		prev_wdata = p_q;
		if (data_we) begin
			next_we = 1'b1;
			prev_we = 1'b1;
		end else if (cmd.commit) begin
			next_we    = p_q != apdll_pkg::NONE_LINK;
			next_waddr = p_q[IW-1:0];
			next_wdata = is_insert ? s_link : nx_q;
			prev_we    = nx_q != apdll_pkg::NONE_LINK;
			prev_waddr = nx_q[IW-1:0];
			prev_wdata = is_insert ? s_link : p_q;
		end
	end

	always_ff @(posedge clk) begin
		if (next_we) next_mem[next_waddr] <= next_wdata;
		if (prev_we) prev_mem[prev_waddr] <= prev_wdata;
		if (data_we) begin
			num_mem[s_q] <= num_q;
			txt_mem[s_q] <= txt_q;
		end
		prev_rd_q <= prev_mem[rd_addr];
		next_rd_q <= next_mem[rd_addr];
		num_rd_q  <= num_mem[rd_addr];
		txt_rd_q  <= txt_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pos_q <= position;
			num_q <= number_value;
			txt_q <= text_word[TW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q     <= apdll_pkg::OP_CLEAR;
			head_q   <= apdll_pkg::NONE_LINK;
			tail_q   <= apdll_pkg::NONE_LINK;
			count_q  <= '0;
			in_use_q <= '0;
			free_q   <= '0;
			status_q <= apdll_pkg::ST_OK;
			s_q      <= '0;
			p_q      <= apdll_pkg::NONE_LINK;
			nx_q     <= apdll_pkg::NONE_LINK;
			done_q   <= 1'b0;
		end else begin
			free_q <= free_d;
			done_q <= cmd.finish;
			if (cmd.accept) begin
				op_q <= apdll_pkg::op_t'(operation);
			end
			if (cmd.check) begin
				status_q <= check_status;
				p_q      <= ins_prev;
				s_q      <= (op_q == apdll_pkg::OP_READ) ? pos_q : free_q;
				if (op_q == apdll_pkg::OP_CLEAR) begin
					head_q   <= apdll_pkg::NONE_LINK;
					tail_q   <= apdll_pkg::NONE_LINK;
					count_q  <= '0;
					in_use_q <= '0;
				end
			end
			if (cmd.fetch) begin
				s_q <= del_slot[IW-1:0];
				if (fetch_bad) status_q <= apdll_pkg::ST_BADPOS;
			end
			if (cmd.link) begin
				if (is_insert) begin
					nx_q <= ins_next;
				end else begin
					p_q  <= prev_rd_q;
					nx_q <= next_rd_q;
				end
			end
			if (cmd.commit) begin
				if (p_q == apdll_pkg::NONE_LINK) head_q <= is_insert ? s_link : nx_q;
				if (nx_q == apdll_pkg::NONE_LINK) tail_q <= is_insert ? s_link : p_q;
				in_use_q[s_q] <= is_insert;
				count_q <= is_insert ? count_q + LW'(1) : count_q - LW'(1);
			end
		end
	end

	// result word; list state is already committed when finish runs
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_status_q <= status_q;
			out_count_q  <= count_q;
			out_head_q   <= head_q;
			out_tail_q   <= tail_q;
			out_slot_q   <= '0;
			out_prev_q   <= apdll_pkg::NONE_LINK;
			out_next_q   <= apdll_pkg::NONE_LINK;
			out_num_q    <= '0;
			out_txt_q    <= '0;
			if (status_q == apdll_pkg::ST_OK && op_q != apdll_pkg::OP_CLEAR) begin
				out_slot_q <= s_q;
			end
			if (status_q == apdll_pkg::ST_OK && op_q == apdll_pkg::OP_READ) begin
				out_prev_q <= prev_rd_q;
				out_next_q <= next_rd_q;
				out_num_q  <= num_rd_q;
				out_txt_q  <= txt_rd_q;
			end
		end
	end

	assign flags.is_insert = is_insert;
	assign flags.is_delete = is_delete;
	assign flags.check_ok  = check_status == apdll_pkg::ST_OK;
	assign flags.fetch_ok  = !fetch_bad;

	assign done        = done_q;
	assign status      = out_status_q;
	assign slot        = out_slot_q;
	assign count       = out_count_q;
	assign head_link   = out_head_q;
	assign tail_link   = out_tail_q;
	assign prev_link   = out_prev_q;
	assign next_link   = out_next_q;
	assign read_number = out_num_q;
	assign read_text   = apdll_pkg::WORD_W'(out_txt_q);

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LW'(N))
		else $error("live count exceeds pool size");

	a_in_use_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(in_use_q) == int'(count_q))
		else $error("in-use bits disagree with live count");

	a_head_tail_empty: assert property (@(posedge clk) disable iff (!arst_n)
		((count_q == '0) == (head_q == apdll_pkg::NONE_LINK)) &&
		((count_q == '0) == (tail_q == apdll_pkg::NONE_LINK)))
		else $error("head/tail disagree with empty list");

	a_commit_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> status_q == apdll_pkg::ST_OK)
		else $error("list committed on a flagged operation");

	a_done_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> done_q)
		else $error("finish step produced no result strobe");
`endif

endmodule

`default_nettype wire
